### sv/ucd_pkg.sv
package ucd_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  localparam logic [CpW-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Work for the back end: a run of replacement code points, then an optional final code point.
  typedef struct packed {
    logic [1:0]     rep_cnt;
    logic           tail_vld;
    logic [CpW-1:0] tail_cp;
  } cmd_t;

endpackage

### sv/ucd_front.sv
module ucd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  output logic          cmd_vld,
  output ucd_pkg::cmd_t cmd
);

  logic [ucd_pkg::CpW-1:0] partial_r, partial_nxt;
  logic [1:0]              expect_r, expect_nxt;
  logic [1:0]              taken_r, taken_nxt;
  logic                    is_cont;

  assign is_cont = (in_byte[7:6] == 2'b10);

  always_comb begin
    partial_nxt  = partial_r;
    expect_nxt   = expect_r;
    taken_nxt    = taken_r;
    cmd.rep_cnt  = 2'd0;
    cmd.tail_vld = 1'b0;
    cmd.tail_cp  = ucd_pkg::REPLACEMENT_CP;
    if ((expect_r != 2'd0) && is_cont) begin
      partial_nxt = {partial_r[ucd_pkg::CpW-7:0], in_byte[5:0]};
      expect_nxt  = expect_r - 2'd1;
      taken_nxt   = taken_r + 2'd1;
      if (expect_r == 2'd1) begin
        cmd.tail_vld = 1'b1;
        cmd.tail_cp  = partial_nxt;
        partial_nxt  = '0;
        taken_nxt    = 2'd0;
      end
    end else begin
      if (expect_r != 2'd0) begin
        cmd.rep_cnt = taken_r + 2'd1;
      end
      partial_nxt = '0;
      expect_nxt  = 2'd0;
      taken_nxt   = 2'd0;
      priority if (in_byte[7] == 1'b0) begin
        cmd.tail_vld = 1'b1;
        cmd.tail_cp  = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
        partial_nxt = {16'd0, in_byte[4:0]};
        expect_nxt  = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_nxt = {17'd0, in_byte[3:0]};
        expect_nxt  = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_nxt = {18'd0, in_byte[2:0]};
        expect_nxt  = 2'd3;
      end else begin
        cmd.tail_vld = 1'b1;
        cmd.tail_cp  = ucd_pkg::REPLACEMENT_CP;
      end
    end
  end

  assign cmd_vld = accept && ((cmd.rep_cnt != 2'd0) || cmd.tail_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      expect_r  <= 2'd0;
      taken_r   <= 2'd0;
    end else if (accept) begin
      partial_r <= partial_nxt;
      expect_r  <= expect_nxt;
      taken_r   <= taken_nxt;
    end
  end

endmodule

### sv/ucd_cmd_queue.sv
module ucd_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ucd_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_vld,
  output ucd_pkg::cmd_t rd_cmd
);

  ucd_pkg::cmd_t                  slot_r [ucd_pkg::QueueDepth];
  logic [ucd_pkg::QueueAw-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ucd_pkg::QueueAw:0]      count_r, count_nxt;
  logic                           do_wr, do_rd;

  assign full   = (count_r == (ucd_pkg::QueueAw+1)'(ucd_pkg::QueueDepth));
  assign rd_vld = (count_r != '0);
  assign rd_cmd = slot_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && rd_vld;

  always_comb begin
    count_nxt = count_r;
    unique case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### sv/ucd_back.sv
module ucd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_vld,
  input  ucd_pkg::cmd_t           q_cmd,
  output logic                    q_rd,
  output logic                    empty,
  input  logic                    pop,
  output logic [ucd_pkg::CpW-1:0] out_code_point,
  output logic                    out_is_end,
  output logic                    out_last
);

  ucd_pkg::cmd_t           cur_r, cur_nxt;
  logic                    cur_vld_r, cur_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic [ucd_pkg::CpW-1:0] cp_r, cp_nxt;
  logic                    last_r, last_nxt;
  logic                    adv;
  logic                    act_vld;
  ucd_pkg::cmd_t           act;

  assign adv     = !out_vld_r || pop;
  assign act_vld = cur_vld_r || q_vld;
  assign act     = cur_vld_r ? cur_r : q_cmd;
  assign q_rd    = adv && !cur_vld_r && q_vld;

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    out_vld_nxt = out_vld_r;
    cp_nxt      = cp_r;
    last_nxt    = last_r;
    if (adv) begin
      out_vld_nxt = act_vld;
      if (act_vld) begin
        cur_nxt = act;
        if (act.rep_cnt != 2'd0) begin
          cp_nxt          = ucd_pkg::REPLACEMENT_CP;
          last_nxt        = (act.rep_cnt == 2'd1) && !act.tail_vld;
          cur_nxt.rep_cnt = act.rep_cnt - 2'd1;
          cur_vld_nxt     = (act.rep_cnt != 2'd1) || act.tail_vld;
        end else begin
          cp_nxt      = act.tail_cp;
          last_nxt    = 1'b1;
          cur_vld_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    cp_r   <= cp_nxt;
    last_r <= last_nxt;
  end

  assign empty          = !out_vld_r;
  assign out_code_point = cp_r;
  assign out_is_end     = (cp_r == '0);
  assign out_last       = last_r;

endmodule

### sv/utf8_codepoint_decoder_core.sv
// Channel  | Ports                                          | Handshake
// ---------+------------------------------------------------+--------------------------
// input    | in_byte                                        | push, full (word on push & !full)
// result   | out_code_point, out_is_end, out_last           | empty, pop (word on pop & !empty)
//
// A byte is decoded in the cycle it is taken and lands in a four-entry command queue.
// While pop does not stall, the back end sends one code point per cycle, so a byte with one
// result sustains one byte per cycle; a broken sequence sends its up to four results in turn.
// A result is registered in the command queue and then in the back end's output register.
// Synchronous active-low reset empties the command queue and output stage and idles the decoder.
// full rises only when the command queue is full; a stalled pop holds the result stable.
module utf8_codepoint_decoder_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              in_byte,
  output logic                    empty,
  input  logic                    pop,
  output logic [ucd_pkg::CpW-1:0] out_code_point,
  output logic                    out_is_end,
  output logic                    out_last
);

  logic          accept;
  logic          cmd_vld;
  ucd_pkg::cmd_t cmd;
  logic          q_vld;
  logic          q_rd;
  ucd_pkg::cmd_t q_cmd;

  assign accept = push && !full;

  ucd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .cmd_vld (cmd_vld),
    .cmd     (cmd)
  );

  ucd_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_vld),
    .wr_cmd (cmd),
    .full   (full),
    .rd_en  (q_rd),
    .rd_vld (q_vld),
    .rd_cmd (q_cmd)
  );

  ucd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (q_vld),
    .q_cmd          (q_cmd),
    .q_rd           (q_rd),
    .empty          (empty),
    .pop            (pop),
    .out_code_point (out_code_point),
    .out_is_end     (out_is_end),
    .out_last       (out_last)
  );

endmodule
